// ----- hw/rtl/dsr_pkg.sv -----
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types, codes and helpers of the Doppler speed readout.
// ----------------------------------------------------------------------------
package dsr_pkg;

    localparam int KEY_W   = 12;
    localparam int HZ_W    = 16;
    localparam int GAIN_W  = 24;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = HZ_W + GAIN_W + 1;
    localparam int SPEED_W = 7;
    localparam int BCD_W   = 8;
    localparam int CFG_IDX_W = 3;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    localparam logic [KEY_W-1:0] KEY_UP_LO    = KEY_W'(700);
    localparam logic [KEY_W-1:0] KEY_UP_HI    = KEY_W'(800);
    localparam logic [KEY_W-1:0] KEY_DOWN_LO  = KEY_W'(1700);
    localparam logic [KEY_W-1:0] KEY_DOWN_HI  = KEY_W'(1900);
    localparam logic [KEY_W-1:0] KEY_LEFT_LO  = KEY_W'(2000);
    localparam logic [KEY_W-1:0] KEY_LEFT_HI  = KEY_W'(3000);
    localparam logic [KEY_W-1:0] KEY_RIGHT    = '0;

    localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(99);
    localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

    localparam logic [GAIN_W-1:0] GAIN_MPS_RST  = GAIN_W'(934);
    localparam logic [GAIN_W-1:0] GAIN_KMH_RST  = GAIN_W'(3363);
    localparam logic [GAIN_W-1:0] GAIN_MPH_RST  = GAIN_W'(2089);
    localparam logic [HZ_W-1:0]   BAND_LOW_RST  = HZ_W'(100);
    localparam logic [HZ_W-1:0]   BAND_HIGH_RST = HZ_W'(600);

    typedef enum logic [1:0] {
        MODE_MENU = 2'd0,
        MODE_ADC  = 2'd1,
        MODE_CMP  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        UNIT_MPS = 2'd0,
        UNIT_KMH = 2'd1,
        UNIT_MPH = 2'd2
    } unit_t;

    typedef enum logic [2:0] {
        KEY_NONE  = 3'd0,
        KEY_UP    = 3'd1,
        KEY_DOWN  = 3'd2,
        KEY_LEFT  = 3'd3,
        KEY_RIGHT_EVT = 3'd4
    } key_evt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_MPS  = 3'd0,
        CFG_GAIN_KMH  = 3'd1,
        CFG_GAIN_MPH  = 3'd2,
        CFG_BAND_LOW  = 3'd3,
        CFG_BAND_HIGH = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] unit;
    } disp_state_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_mps;
        logic [GAIN_W-1:0] gain_kmh;
        logic [GAIN_W-1:0] gain_mph;
        logic [HZ_W-1:0]   band_low;
        logic [HZ_W-1:0]   band_high;
    } cfg_t;

    function automatic logic [BCD_W-1:0] to_bcd(input logic [SPEED_W-1:0] v);
        logic [3:0]         tens;
        logic [SPEED_W-1:0] rem;
        tens = 4'd0;
        for (int t = 1; t <= 9; t++) begin
            if (v >= SPEED_W'(t * 10))
            begin
                tens = 4'(t);
            end
        end
        rem = v - SPEED_W'({tens, 3'b000}) - SPEED_W'({tens, 1'b0});
        return {tens, rem[3:0]};
    endfunction

endpackage

// ----- hw/rtl/doppler_speed_readout_core.sv -----
// ----------------------------------------------------------------------------
// doppler_speed_readout_core
// Keypad-driven Doppler speed readout: mode/unit control and speed display.
//
// Channel  Dir  Payload (lowest bits first)
// s_*      in   key_level[11:0], adc_path_hz[27:12], comparator_path_hz[43:28]
// m_*      out  current_mode[1:0], current_unit[3:2], shown_hz[19:4], speed_bcd[27:20]
// cfg_*    in   cfg_index selects register 0..4, cfg_data up to 24 bits
//
// One request per cycle sustained while m_tready stays high.
// Input register, then one pass of decode, band gate and multiply into the
// output register. Mode and unit advance when a request moves to the output.
// A stall on m_tready holds both stages; s_tready stays high while the input
// register can drain. Reset clears mode to menu, unit to m/s and the registers
// to their defaults.
// ----------------------------------------------------------------------------
module doppler_speed_readout_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // key_level, adc_path_hz, comparator_path_hz, zero pad
    input  logic [dsr_pkg::S_DATA_W-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // current_mode, current_unit, shown_hz, speed_bcd, zero pad
    output logic [dsr_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                cfg_we,
    input  logic [dsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dsr_pkg::GAIN_W-1:0]          cfg_data
);
    import dsr_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HZ_W-1:0]   adc_hz_reg;
    logic [HZ_W-1:0]   cmp_hz_reg;
    logic              out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;
    logic [M_DATA_W-1:0] out_data_next;
    logic              advance;
    logic              out_free;
    disp_state_t       disp_state;
    logic [HZ_W-1:0]   shown_hz;
    logic [BCD_W-1:0]  speed_bcd;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_mps  <= GAIN_MPS_RST;
            cfg_reg.gain_kmh  <= GAIN_KMH_RST;
            cfg_reg.gain_mph  <= GAIN_MPH_RST;
            cfg_reg.band_low  <= BAND_LOW_RST;
            cfg_reg.band_high <= BAND_HIGH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAIN_MPS:  cfg_reg.gain_mps  <= cfg_data;
                CFG_GAIN_KMH:  cfg_reg.gain_kmh  <= cfg_data;
                CFG_GAIN_MPH:  cfg_reg.gain_mph  <= cfg_data;
                CFG_BAND_LOW:  cfg_reg.band_low  <= cfg_data[HZ_W-1:0];
                CFG_BAND_HIGH: cfg_reg.band_high <= cfg_data[HZ_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            key_reg    <= s_tdata[KEY_W-1:0];
            adc_hz_reg <= s_tdata[KEY_W+HZ_W-1:KEY_W];
            cmp_hz_reg <= s_tdata[KEY_W+2*HZ_W-1:KEY_W+HZ_W];
        end
    end

    dsr_mode_ctrl u_mode_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_level (key_reg),
        .advance   (advance),
        .state_out (disp_state)
    );

    dsr_speed_calc u_speed_calc (
        .state_in           (disp_state),
        .cfg                (cfg_reg),
        .adc_path_hz        (adc_hz_reg),
        .comparator_path_hz (cmp_hz_reg),
        .shown_hz           (shown_hz),
        .speed_bcd          (speed_bcd)
    );

    assign out_data_next = M_DATA_W'({speed_bcd, shown_hz, disp_state.unit, disp_state.mode});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ----- hw/rtl/dsr_mode_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsr_mode_ctrl
// Keypad level decoder with the mode and unit registers.
// ----------------------------------------------------------------------------
module dsr_mode_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [dsr_pkg::KEY_W-1:0] key_level,
    input  logic                      advance,
    output dsr_pkg::disp_state_t      state_out
);
    import dsr_pkg::*;

    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic [1:0] unit_reg;
    logic [1:0] unit_next;
    key_evt_t   key_evt;

    always_comb
    begin
        if (key_level > KEY_UP_LO && key_level < KEY_UP_HI)
        begin
            key_evt = KEY_UP;
        end
        else if (key_level > KEY_DOWN_LO && key_level < KEY_DOWN_HI)
        begin
            key_evt = KEY_DOWN;
        end
        else if (key_level > KEY_LEFT_LO && key_level < KEY_LEFT_HI)
        begin
            key_evt = KEY_LEFT;
        end
        else if (key_level == KEY_RIGHT)
        begin
            key_evt = KEY_RIGHT_EVT;
        end
        else
        begin
            key_evt = KEY_NONE;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        unit_next = unit_reg;
        unique case (key_evt)
            KEY_UP:        mode_next = MODE_MENU;
            KEY_DOWN:      unit_next = (unit_reg >= UNIT_MPH) ? UNIT_MPS : unit_reg + 2'd1;
            KEY_LEFT:      mode_next = MODE_ADC;
            KEY_RIGHT_EVT: mode_next = MODE_CMP;
            default:       ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MENU;
            unit_reg <= UNIT_MPS;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            unit_reg <= unit_next;
        end
    end

    assign state_out.mode = mode_next;
    assign state_out.unit = unit_next;

endmodule

// ----- hw/rtl/dsr_speed_calc.sv -----
// ----------------------------------------------------------------------------
// dsr_speed_calc
// Source select, band gate, gain multiply, rounding, clamp and BCD split.
// ----------------------------------------------------------------------------
module dsr_speed_calc (
    input  dsr_pkg::disp_state_t      state_in,
    input  dsr_pkg::cfg_t             cfg,
    input  logic [dsr_pkg::HZ_W-1:0]  adc_path_hz,
    input  logic [dsr_pkg::HZ_W-1:0]  comparator_path_hz,
    output logic [dsr_pkg::HZ_W-1:0]  shown_hz,
    output logic [dsr_pkg::BCD_W-1:0] speed_bcd
);
    import dsr_pkg::*;

    logic [HZ_W-1:0]    src_hz;
    logic [GAIN_W-1:0]  gain;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  rounded;
    logic [SPEED_W-1:0] speed;
    logic               active;

    assign active = (state_in.mode == MODE_ADC) || (state_in.mode == MODE_CMP);

    always_comb
    begin
        case (state_in.mode)
            MODE_ADC: src_hz = adc_path_hz;
            MODE_CMP: src_hz = comparator_path_hz;
            default:  src_hz = '0;
        endcase
    end

    always_comb
    begin
        case (state_in.unit)
            UNIT_KMH: gain = cfg.gain_kmh;
            UNIT_MPH: gain = cfg.gain_mph;
            default:  gain = cfg.gain_mps;
        endcase
    end

    assign shown_hz = (src_hz >= cfg.band_low && src_hz <= cfg.band_high) ? src_hz : '0;

    assign prod    = PROD_W'(shown_hz) * PROD_W'(gain);
    assign rounded = (prod + ROUND_HALF) >> FRAC_W;

    always_comb
    begin
        if (!active)
        begin
            speed = '0;
        end
        else if (rounded > PROD_W'(SPEED_MAX))
        begin
            speed = SPEED_MAX;
        end
        else
        begin
            speed = rounded[SPEED_W-1:0];
        end
    end

    assign speed_bcd = to_bcd(speed);

endmodule
